[rtl/core/kbe_pkg.sv]
// Shared types and constants for the keyframe Bezier ease interpolator.
package kbe_pkg;

    // Fixed-point constants (progress and curve parameter are unsigned Q1.16).
    localparam int ONE_Q16          = 65536;
    localparam int TOL_Q16          = 7;
    localparam int BISECT_STEPS_DEF = 14;
    localparam int DIV_STEPS        = 16;

    // Shared multiplier operand widths.
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Accumulator and estimate widths.
    localparam int ACC_W = 72;
    localparam int EST_W = 27;

    // Micro-steps of one curve evaluation.
    localparam logic [3:0] K_UT   = 4'd0;
    localparam logic [3:0] K_UP1  = 4'd1;
    localparam logic [3:0] K_TP2  = 4'd2;
    localparam logic [3:0] K_TT   = 4'd3;
    localparam logic [3:0] K_SUL  = 4'd4;
    localparam logic [3:0] K_SUH  = 4'd5;
    localparam logic [3:0] K_T3   = 4'd6;
    localparam logic [3:0] K_X3   = 4'd7;
    localparam logic [3:0] K_ADD  = 4'd8;
    localparam logic [3:0] K_EST  = 4'd9;

    // Micro-steps of the final blend.
    localparam logic [3:0] K_BLO  = 4'd0;
    localparam logic [3:0] K_BHI  = 4'd1;
    localparam logic [3:0] K_BSUM = 4'd2;
    localparam logic [3:0] K_BOUT = 4'd3;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_BEZ   = 5'b00100,
        ST_BLEND = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

endpackage

[rtl/core/keyframe_bezier_ease_interpolator.sv]
// Top level: sequencer around one shared multiplier for eased keyframe blending.
// Sequence: a hold or empty-segment item goes straight to the hand-off; otherwise a divide
// (skipped when progress clamps), curve evaluations (up to BISECT_STEPS for x, one for y),
// the blend and the hand-off to the output register.
// Throughput: one item at a time; a new item is taken only once the sequencer is back in idle,
// and the hand-off waits while the output holds a result not yet taken by i_m_axis_tready.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_m_axis_tvalid.
module keyframe_bezier_ease_interpolator #(
    parameter int BISECT_STEPS = kbe_pkg::BISECT_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // frame_time, seg_start_time, seg_end_time, start_value, end_value,
    // ease_out_x, ease_out_y, ease_in_x, ease_in_y
    input  logic [223:0] i_s_axis_tdata,
    // hold_flag
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_value
    output logic [31:0]  o_m_axis_tdata
);

    localparam int IW = $clog2(BISECT_STEPS + 1);
    localparam int AW = kbe_pkg::MUL_AW;
    localparam int BW = kbe_pkg::MUL_BW;
    localparam int PW = kbe_pkg::MUL_PW;
    localparam int ACC_W = kbe_pkg::ACC_W;
    localparam int EST_W = kbe_pkg::EST_W;

    // Input fields.
    logic signed [31:0] frame_time, seg_start_time, seg_end_time, start_value, end_value;
    logic signed [15:0] ease_out_x, ease_out_y, ease_in_x, ease_in_y;
    logic               hold_flag;

    assign frame_time     = i_s_axis_tdata[31:0];
    assign seg_start_time = i_s_axis_tdata[63:32];
    assign seg_end_time   = i_s_axis_tdata[95:64];
    assign start_value    = i_s_axis_tdata[127:96];
    assign end_value      = i_s_axis_tdata[159:128];
    assign ease_out_x     = i_s_axis_tdata[175:160];
    assign ease_out_y     = i_s_axis_tdata[191:176];
    assign ease_in_x      = i_s_axis_tdata[207:192];
    assign ease_in_y      = i_s_axis_tdata[223:208];
    assign hold_flag      = i_s_axis_tuser;

    // Registers.
    kbe_pkg::t_state            r_state, n_state;
    logic [3:0]                 r_k, n_k;
    logic [IW-1:0]              r_iter, n_iter;
    logic                       r_eval_y, n_eval_y;
    logic signed [31:0]         r_v0, n_v0;
    logic signed [32:0]         r_diff, n_diff;
    logic signed [15:0]         r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic [32:0]                r_den, n_den;
    logic [32:0]                r_rem, n_rem;
    logic [16:0]                r_p, n_p;
    logic [16:0]                r_t, n_t, r_lo, n_lo, r_hi, n_hi;
    logic [32:0]                r_ut, n_ut;
    logic [32:0]                r_tt, n_tt;
    logic signed [34:0]         r_s, n_s;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [PW-1:0]       r_t3, n_t3;
    logic signed [EST_W-1:0]    r_y, n_y;
    logic [31:0]                r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    logic [31:0]                r_out, n_out;

    // Shared multiplier.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    kbe_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Helper values.
    logic               s_accept;
    logic signed [32:0] in_num, in_den;
    logic [16:0]        u_val;
    logic signed [15:0] cp1, cp2;
    logic [33:0]        rem2;
    logic signed [ACC_W-1:0] est_full;
    logic signed [EST_W-1:0] est;
    logic signed [EST_W:0]   est_d;
    logic [17:0]        mid_sum;
    logic signed [ACC_W-1:0] blend_sum;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == kbe_pkg::ST_IDLE);
    assign in_num          = 33'(frame_time) - 33'(seg_start_time);
    assign in_den          = 33'(seg_end_time) - 33'(seg_start_time);
    assign u_val           = 17'(kbe_pkg::ONE_Q16) - r_t;
    assign cp1             = r_eval_y ? r_y1 : r_x1;
    assign cp2             = r_eval_y ? r_y2 : r_x2;
    assign rem2            = {r_rem, 1'b0};
    assign est_full        = (r_acc + (ACC_W'(1) <<< 43)) >>> 44;
    assign est             = est_full[EST_W-1:0];
    assign est_d           = (EST_W+1)'(est) - (EST_W+1)'($signed({1'b0, r_p}));
    assign mid_sum         = 18'(r_lo) + 18'(r_hi);
    assign blend_sum       = ((r_acc + ACC_W'(32768)) >>> 16) + ACC_W'(r_v0);

    // Multiplier operand selection by micro-step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == kbe_pkg::ST_BEZ) begin
            unique case (r_k)
                kbe_pkg::K_UT: begin
                    mul_a = AW'({1'b0, u_val});
                    mul_b = BW'({1'b0, r_t});
                end
                kbe_pkg::K_UP1: begin
                    mul_a = AW'({1'b0, u_val});
                    mul_b = BW'(cp1);
                end
                kbe_pkg::K_TP2: begin
                    mul_a = AW'({1'b0, r_t});
                    mul_b = BW'(cp2);
                end
                kbe_pkg::K_TT: begin
                    mul_a = AW'({1'b0, r_t});
                    mul_b = BW'({1'b0, r_t});
                end
                kbe_pkg::K_SUL: begin
                    mul_a = AW'(r_s);
                    mul_b = BW'({1'b0, r_ut[15:0]});
                end
                kbe_pkg::K_SUH: begin
                    mul_a = AW'(r_s);
                    mul_b = BW'({1'b0, r_ut[32:16]});
                end
                kbe_pkg::K_T3: begin
                    mul_a = AW'({1'b0, r_tt});
                    mul_b = BW'({1'b0, r_t});
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (r_state == kbe_pkg::ST_BLEND) begin
            mul_a = AW'(r_diff);
            if (r_k == kbe_pkg::K_BLO) begin
                mul_b = BW'({1'b0, r_y[16:0]});
            end else begin
                // The upper part of y carries the sign.
                mul_b = BW'($signed(r_y[EST_W-1:17]));
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;  n_k = r_k;  n_iter = r_iter;  n_eval_y = r_eval_y;
        n_v0 = r_v0;  n_diff = r_diff;
        n_x1 = r_x1;  n_y1 = r_y1;  n_x2 = r_x2;  n_y2 = r_y2;
        n_den = r_den;  n_rem = r_rem;  n_p = r_p;
        n_t = r_t;  n_lo = r_lo;  n_hi = r_hi;
        n_ut = r_ut;  n_tt = r_tt;  n_s = r_s;  n_acc = r_acc;  n_t3 = r_t3;  n_y = r_y;
        n_res = r_res;
        n_out_valid = r_out_valid;  n_out = r_out;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            kbe_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_v0 = start_value;
                    n_diff = 33'(end_value) - 33'(start_value);
                    n_x1 = ease_out_x;  n_y1 = ease_out_y;
                    n_x2 = ease_in_x;   n_y2 = ease_in_y;
                    n_den = in_den;
                    n_rem = in_num;
                    n_k = '0;
                    n_iter = '0;
                    n_eval_y = 1'b0;
                    n_lo = '0;
                    n_hi = 17'(kbe_pkg::ONE_Q16);
                    if (hold_flag || in_den <= 0) begin
                        n_res = start_value;
                        n_state = kbe_pkg::ST_DONE;
                    end else if (in_num <= 0) begin
                        n_p = '0;  n_t = '0;
                        n_state = kbe_pkg::ST_BEZ;
                    end else if (in_num >= in_den) begin
                        n_p = 17'(kbe_pkg::ONE_Q16);
                        n_t = 17'(kbe_pkg::ONE_Q16);
                        n_state = kbe_pkg::ST_BEZ;
                    end else begin
                        n_p = '0;
                        n_state = kbe_pkg::ST_DIV;
                    end
                end
            end

            // Restoring division, one quotient bit per cycle.
            kbe_pkg::ST_DIV: begin
                if (rem2 >= {1'b0, r_den}) begin
                    n_rem = 33'(rem2 - {1'b0, r_den});
                    n_p = {r_p[15:0], 1'b1};
                end else begin
                    n_rem = rem2[32:0];
                    n_p = {r_p[15:0], 1'b0};
                end
                n_k = r_k + 4'd1;
                if (r_k == 4'(kbe_pkg::DIV_STEPS - 1)) begin
                    n_t = {r_p[15:0], (rem2 >= {1'b0, r_den})};
                    n_k = '0;
                    n_state = kbe_pkg::ST_BEZ;
                end
            end

            // One curve evaluation, at most one multiply per step.
            kbe_pkg::ST_BEZ: begin
                n_k = r_k + 4'd1;
                unique case (r_k)
                    kbe_pkg::K_UT:  begin end
                    kbe_pkg::K_UP1: n_ut = mul_p[32:0];
                    kbe_pkg::K_TP2: n_s = 35'(mul_p);
                    kbe_pkg::K_TT:  n_s = r_s + 35'(mul_p);
                    kbe_pkg::K_SUL: n_tt = mul_p[32:0];
                    kbe_pkg::K_SUH: n_acc = ACC_W'(mul_p);
                    kbe_pkg::K_T3:  n_acc = r_acc + (ACC_W'(mul_p) <<< 16);
                    kbe_pkg::K_X3: begin
                        n_t3 = mul_p;
                        n_acc = r_acc + (r_acc <<< 1);
                    end
                    kbe_pkg::K_ADD: n_acc = r_acc + (ACC_W'(r_t3) <<< 12);
                    kbe_pkg::K_EST: begin
                        n_k = '0;
                        if (r_eval_y) begin
                            n_y = est;
                            n_state = kbe_pkg::ST_BLEND;
                        end else if (est_d > -(EST_W+1)'(kbe_pkg::TOL_Q16) &&
                                     est_d < (EST_W+1)'(kbe_pkg::TOL_Q16)) begin
                            n_eval_y = 1'b1;
                        end else begin
                            if (est_d < 0) begin
                                n_lo = r_t;
                                n_t = 17'((18'(r_t) + 18'(r_hi)) >> 1);
                            end else begin
                                n_hi = r_t;
                                n_t = 17'((18'(r_lo) + 18'(r_t)) >> 1);
                            end
                            n_iter = r_iter + IW'(1);
                            if (r_iter + IW'(1) == IW'(BISECT_STEPS)) begin
                                n_eval_y = 1'b1;
                            end
                        end
                    end
                    default: n_k = '0;
                endcase
            end

            // Blend: diff * y in two partial products, round, add, saturate.
            kbe_pkg::ST_BLEND: begin
                n_k = r_k + 4'd1;
                unique case (r_k)
                    kbe_pkg::K_BLO:  begin end
                    kbe_pkg::K_BHI:  n_acc = ACC_W'(mul_p);
                    kbe_pkg::K_BSUM: n_acc = r_acc + (ACC_W'(mul_p) <<< 17);
                    kbe_pkg::K_BOUT: begin
                        if (blend_sum > ACC_W'(32'sh7fffffff)) begin
                            n_res = 32'h7fffffff;
                        end else if (blend_sum < -ACC_W'(33'sh080000000)) begin
                            n_res = 32'h80000000;
                        end else begin
                            n_res = blend_sum[31:0];
                        end
                        n_state = kbe_pkg::ST_DONE;
                    end
                    default: n_k = '0;
                endcase
            end

            // Hand the result to the output register once it is free.
            kbe_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                    n_state = kbe_pkg::ST_IDLE;
                end
            end

            default: n_state = kbe_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_k <= '0;
            r_iter <= '0;
            r_eval_y <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_k <= n_k;
            r_iter <= n_iter;
            r_eval_y <= n_eval_y;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_v0 <= n_v0;  r_diff <= n_diff;
        r_x1 <= n_x1;  r_y1 <= n_y1;  r_x2 <= n_x2;  r_y2 <= n_y2;
        r_den <= n_den;  r_rem <= n_rem;  r_p <= n_p;
        r_t <= n_t;  r_lo <= n_lo;  r_hi <= n_hi;
        r_ut <= n_ut;  r_tt <= n_tt;  r_s <= n_s;  r_acc <= n_acc;  r_t3 <= n_t3;
        r_y <= n_y;  r_res <= n_res;  r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Bisection bounds stay ordered and bracket the current point.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbe_pkg::ST_BEZ) |-> (r_lo <= r_t && r_t <= r_hi))
        else $error("bisection bounds out of order");

    a_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= IW'(BISECT_STEPS))
        else $error("bisection step count overrun");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && hold_flag) |=> (r_state == kbe_pkg::ST_DONE && r_res == $past(start_value)))
        else $error("hold item did not pass the start value");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbe_pkg::ST_BEZ) |-> (r_k <= kbe_pkg::K_EST))
        else $error("curve micro-step out of range");

    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbe_pkg::ST_BEZ && r_k == kbe_pkg::K_EST) |-> mid_sum <= 18'(131072))
        else $error("bisection midpoint out of range");

endmodule

[rtl/core/kbe_mul.sv]
// Shared signed multiplier with a registered product.
module kbe_mul #(
    parameter int AW = kbe_pkg::MUL_AW,
    parameter int BW = kbe_pkg::MUL_BW
) (
    input  logic                     i_clk,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);

    logic signed [AW+BW-1:0] r_p;

    // One product per cycle, available on the next cycle.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
